@@ src/partition_label_canonicalizer_unit_defines.svh @@
// Assertion macros for the label canonicalizer.
// Properties passed in must not contain a top-level comma.
`ifndef PARTITION_LABEL_CANONICALIZER_UNIT_DEFINES_SVH
`define PARTITION_LABEL_CANONICALIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PLC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PLC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plc assertion failed");

`endif

@@ src/plc_pkg.sv @@
package plc_pkg;

	// Number of class slots; labels index the slots directly
	localparam int LABEL_COUNT = 256;
	localparam int SLOT_W      = $clog2(LABEL_COUNT);
	localparam int LABEL_W     = 8;
	// Next-number counter can reach LABEL_COUNT itself
	localparam int COUNT_W     = 9;

	// Result beat handed from the table stage to the output register
	typedef struct packed {
		logic [LABEL_W-1:0] canonical_label;
		logic               last_out;
	} plc_beat_t;

endpackage

@@ src/partition_label_canonicalizer_unit.sv @@
// Channel  | Dir | Signals                         | Contents
// s_axis   | in  | tvalid tready tdata[7:0] tlast  | label, last
// m_axis   | out | tvalid tready tdata[7:0] tlast  | canonical_label, last_out
//
// One label per cycle unless m_axis stalls; via table stage, output register.
// The rate is set by the single map memory read or write per beat.
// Reset clears all seen marks and the counter at once; no sweep is needed.
// A stalled output beat is held in the output register; the input keeps
// flowing until the table stage also fills.
module partition_label_canonicalizer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [plc_pkg::LABEL_W-1:0]  s_axis_tdata,  // [7:0] label
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [plc_pkg::LABEL_W-1:0]  m_axis_tdata,  // [7:0] canonical_label
	output logic                         m_axis_tlast
);

	logic               beat_valid;
	logic               beat_take;
	plc_pkg::plc_beat_t beat;

	plc_class_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.label     (s_axis_tdata),
		.last      (s_axis_tlast),
		.beat_valid(beat_valid),
		.beat      (beat),
		.beat_take (beat_take)
	);

	plc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat_valid(beat_valid),
		.beat      (beat),
		.beat_take (beat_take),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ src/plc_class_table.sv @@
// Class map memory, seen marks and next-number counter.
// The map entry of a new class is written at the edge that accepts it, so
// a later beat with the same label reads the written value with no bypass.
module plc_class_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [plc_pkg::LABEL_W-1:0]  label,
	input  logic                         last,
	output logic                         beat_valid,
	output plc_pkg::plc_beat_t           beat,
	input  logic                         beat_take
);

	logic [plc_pkg::LABEL_W-1:0] map_mem [plc_pkg::LABEL_COUNT];
	logic [plc_pkg::LABEL_COUNT-1:0] seen_q;
	logic [plc_pkg::COUNT_W-1:0] count_q;
	logic [plc_pkg::LABEL_W-1:0] rd_q;

	logic                        valid_s1;
	logic                        new_s1;
	logic [plc_pkg::LABEL_W-1:0] num_s1;
	logic                        last_s1;

	logic                        acc;
	logic                        hit;
	logic [plc_pkg::SLOT_W-1:0]  slot;

	// Slot select: a label wraps modulo the slot count
	assign slot     = label[plc_pkg::SLOT_W-1:0];
	assign hit      = seen_q[slot];
	assign in_ready = !valid_s1 || beat_take;
	assign acc      = in_valid && in_ready;

	// Seen marks and counter; a closing beat clears both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			count_q <= '0;
		end else if (acc) begin
			if (last) begin
				seen_q  <= '0;
				count_q <= '0;
			end else if (!hit) begin
				seen_q[slot] <= 1'b1;
				count_q      <= count_q + plc_pkg::COUNT_W'(1);
			end
		end
	end

	// Map memory: write on first sight, registered read otherwise
	always_ff @(posedge clk) begin
		if (acc && !hit) begin
			map_mem[slot] <= count_q[plc_pkg::LABEL_W-1:0];
		end
		if (acc && hit) begin
			rd_q <= map_mem[slot];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			new_s1  <= !hit;
			num_s1  <= count_q[plc_pkg::LABEL_W-1:0];
			last_s1 <= last;
		end
	end

	assign beat_valid           = valid_s1;
	assign beat.canonical_label = new_s1 ? num_s1 : rd_q;
	assign beat.last_out        = last_s1;

endmodule

@@ src/plc_out_stage.sv @@
// Output register: holds a finished beat while the sink stalls.
module plc_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         beat_valid,
	input  plc_pkg::plc_beat_t           beat,
	output logic                         beat_take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [plc_pkg::LABEL_W-1:0]  out_data,
	output logic                         out_last
);

	logic out_valid_q;

	assign beat_take = beat_valid && (!out_valid_q || out_ready);

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= beat_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (beat_take) begin
			out_data <= beat.canonical_label;
			out_last <= beat.last_out;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/plc_checker.sv @@
`include "partition_label_canonicalizer_unit_defines.svh"

// Port-level checks for the label canonicalizer.
module plc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [plc_pkg::LABEL_W-1:0]  m_axis_tdata,
	input logic                         m_axis_tlast
);

	logic [plc_pkg::COUNT_W-1:0] nxt_q;
	logic                        first_q;
	logic                        out_acc;
	logic                        out_stall;
	logic                        in_stall;
	logic [plc_pkg::COUNT_W-1:0] out_num;
	logic [plc_pkg::LABEL_W:0]   out_word;

	assign out_acc   = m_axis_tvalid && m_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign in_stall  = s_axis_tvalid && !s_axis_tready;
	assign out_num   = {1'b0, m_axis_tdata};
	assign out_word  = {m_axis_tlast, m_axis_tdata};

	// Track the next fresh number and vector start as seen on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_q   <= '0;
			first_q <= 1'b1;
		end else if (out_acc) begin
			first_q <= m_axis_tlast;
			if (m_axis_tlast) begin
				nxt_q <= '0;
			end else if (out_num == nxt_q) begin
				nxt_q <= nxt_q + plc_pkg::COUNT_W'(1);
			end
		end
	end

	// Stalled output beat holds
	`PLC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_word))
	// First beat of a vector is always number zero
	`PLC_ASSERT_IMPL(a_first_zero, clk, arst_n, m_axis_tvalid && first_q, m_axis_tdata == '0)
	// Numbers grow by at most one past the largest handed out
	`PLC_ASSERT_IMPL(a_growth, clk, arst_n, m_axis_tvalid, out_num <= nxt_q)
	// Input only backs up behind a stalled output beat
	`PLC_ASSERT_IMPL(a_in_stall, clk, arst_n, in_stall, out_stall)

endmodule

bind partition_label_canonicalizer_unit plc_checker u_plc_checker (.*);
